FILE: hdl/assert_macros.svh
// Assertion helpers for the checker in utf7d_checker.sv.
// The clock is named clock and the synchronous reset is named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset.
`define UTF7D_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check at every edge, reset included.
`define UTF7D_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/utf7d_pkg.sv
`timescale 1ns / 1ps

package utf7d_pkg;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] SURR_FIRST = 8'hD8;
   localparam logic [7:0] SURR_LIMIT = 8'hDC;

   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_PLUS   = 2'd1;
   localparam logic [1:0] MODE_B64    = 2'd2;

   // Units produced by one byte: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0]  count;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } utf7d_units_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_run;
   } utf7d_beat_type;

   // Bit 6 set when c is a base64 symbol, bits 5:0 its value.
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [7:0] d;
      logic [6:0] v;
      v = 7'd0;
      d = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
         v = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h47;
         v = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c + 8'h04;
         v = {1'b1, d[5:0]};
      end else if (c == CHAR_PLUS) begin
         v = {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
         v = {1'b1, 6'd63};
      end
      return v;
   endfunction

endpackage

FILE: hdl/utf7d_decode.sv
`timescale 1ns / 1ps

module utf7d_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_b64,
   input  logic [7:0]                 item_byte,
   input  logic                       item_start,
   input  logic                       commit,
   output utf7d_pkg::utf7d_units_type units
);
   import utf7d_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] carry_ff, carry_in;
   logic [1:0] held_ff, held_in;
   logic [7:0] store_ff [0:2];
   logic [7:0] store_in [0:2];
   logic [6:0] sym;
   logic [7:0] nb;
   logic       have;
   logic       b64_path;
   logic       direct_path;

   assign sym = b64_value(item_byte);

   always_comb begin
      mode_in     = mode_ff;
      slot_in     = slot_ff;
      carry_in    = carry_ff;
      held_in     = held_ff;
      store_in    = store_ff;
      units       = '0;
      nb          = 8'd0;
      have        = 1'b1;
      b64_path    = 1'b0;
      direct_path = 1'b0;

      // A new string restarts packing.
      if (item_start) begin
         slot_in  = 2'd0;
         carry_in = 8'd0;
         held_in  = 2'd0;
         mode_in  = start_b64 ? MODE_B64 : MODE_DIRECT;
      end

      case (mode_in)
         MODE_B64: begin
            b64_path = 1'b1;
         end
         MODE_PLUS: begin
            if (item_byte == CHAR_MINUS) begin
               mode_in     = MODE_DIRECT;
               units.count = 2'd1;
               units.unit0 = {8'h00, CHAR_PLUS};
            end else begin
               slot_in  = 2'd0;
               carry_in = 8'd0;
               held_in  = 2'd0;
               mode_in  = MODE_B64;
               b64_path = 1'b1;
            end
         end
         default: begin
            direct_path = 1'b1;
         end
      endcase

      if (b64_path) begin
         if (!sym[6]) begin
            // Leave the shift; drop leftover bits.
            mode_in = MODE_DIRECT;
            held_in = 2'd0;
            if (item_byte != CHAR_MINUS) begin
               direct_path = 1'b1;
            end
         end else begin
            case (slot_in)
               2'd0: begin
                  carry_in = {sym[5:0], 2'b00};
                  have     = 1'b0;
               end
               2'd1: begin
                  nb       = carry_in | {6'd0, sym[5:4]};
                  carry_in = {sym[3:0], 4'h0};
               end
               2'd2: begin
                  nb       = carry_in | {4'd0, sym[5:2]};
                  carry_in = {sym[1:0], 6'd0};
               end
               default: begin
                  nb = carry_in | {2'b00, sym[5:0]};
               end
            endcase
            slot_in = slot_in + 2'd1;
            if (have) begin
               case (held_in)
                  2'd0: begin
                     store_in[0] = nb;
                     held_in     = 2'd1;
                  end
                  2'd1: begin
                     if (store_in[0] < SURR_FIRST || store_in[0] >= SURR_LIMIT) begin
                        units.count = 2'd1;
                        units.unit0 = {store_in[0], nb};
                        held_in     = 2'd0;
                     end else begin
                        store_in[1] = nb;
                        held_in     = 2'd2;
                     end
                  end
                  2'd2: begin
                     store_in[2] = nb;
                     held_in     = 2'd3;
                  end
                  default: begin
                     units.count = 2'd2;
                     units.unit0 = {store_in[0], store_in[1]};
                     units.unit1 = {store_in[2], nb};
                     held_in     = 2'd0;
                  end
               endcase
            end
         end
      end

      if (direct_path) begin
         if (item_byte == CHAR_PLUS) begin
            mode_in = MODE_PLUS;
         end else begin
            mode_in     = MODE_DIRECT;
            units.count = 2'd1;
            units.unit0 = {8'h00, item_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DIRECT;
         slot_ff  <= 2'd0;
         carry_ff <= 8'd0;
         held_ff  <= 2'd0;
      end else if (commit) begin
         mode_ff  <= mode_in;
         slot_ff  <= slot_in;
         carry_ff <= carry_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         store_ff <= store_in;
      end
   end

endmodule

FILE: hdl/utf7d_out_buf.sv
`timescale 1ns / 1ps

module utf7d_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf7d_pkg::utf7d_units_type units,
   output logic [1:0]                 free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output utf7d_pkg::utf7d_beat_type  head
);
   import utf7d_pkg::*;

   logic [1:0]     count_ff, count_in;
   utf7d_beat_type slot_ff [0:1];
   utf7d_beat_type slot_in [0:1];
   logic           pop;
   logic [1:0]     base;
   logic [1:0]     push_n;
   utf7d_beat_type beat0;
   utf7d_beat_type beat1;

   assign pop    = (count_ff != 2'd0) && rsp_tready;
   assign free   = 2'd2 - count_ff + {1'b0, pop};
   assign base   = count_ff - {1'b0, pop};
   assign push_n = push ? units.count : 2'd0;

   assign beat0 = '{code_unit: units.unit0, last_of_run: (units.count == 2'd1)};
   assign beat1 = '{code_unit: units.unit1, last_of_run: 1'b1};

   always_comb begin
      count_in   = base + push_n;
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (push_n != 2'd0) begin
         if (base == 2'd0) begin
            slot_in[0] = beat0;
         end else begin
            slot_in[1] = beat0;
         end
      end
      if (push_n == 2'd2) begin
         slot_in[1] = beat1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign head       = slot_ff[0];

endmodule

FILE: hdl/utf7_to_utf16_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// req_*     in         tdata[7:0] text_byte, tuser string_start
// rsp_*     out        tdata[15:0] code_unit, tlast last_of_run
// csr_*     in         write_data start_in_base64 (write only)
//
// Takes one byte per cycle while rsp is not stalled. A byte is held in the input
// register, then decoded into the two-slot output buffer, whose head drives rsp.
// A byte that completes a surrogate pair puts both units in the buffer, and they
// leave one after the other through the buffer's single read port. Reset is
// synchronous: it clears the mode, packing state, buffer count and the
// configuration bit. A stall on rsp holds the buffer and, once it is full, the
// input register.

module utf7_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] string_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tlast,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import utf7d_pkg::*;

   logic            start_b64_ff, start_b64_in;
   logic            item_valid_ff, item_valid_in;
   logic [7:0]      item_byte_ff;
   logic            item_start_ff;
   logic            accept;
   logic            commit;
   logic [1:0]      free;
   utf7d_units_type units;
   utf7d_beat_type  head;

   // Configuration bit: take the write whenever the enable is high.
   assign start_b64_in = csr_write_enable ? csr_write_data : start_b64_ff;

   // Commit the held byte once the buffer has room for all its units;
   // a byte with no units commits at once.
   assign commit     = item_valid_ff && (units.count <= free);
   assign req_tready = !item_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (commit) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_b64_ff  <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         start_b64_ff  <= start_b64_in;
         item_valid_ff <= item_valid_in;
      end
   end

   // Input payload: load on each accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_byte_ff  <= req_tdata;
         item_start_ff <= req_tuser;
      end
   end

   // Mode, bit packing and surrogate hold-back.
   utf7d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .start_b64  (start_b64_ff),
      .item_byte  (item_byte_ff),
      .item_start (item_start_ff),
      .commit     (commit),
      .units      (units)
   );

   // Result register, two units deep so a pair drains while bytes keep flowing.
   utf7d_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (commit),
      .units      (units),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.code_unit;
   assign rsp_tlast = head.last_of_run;

endmodule

FILE: hdl/utf7d_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf7d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        rsp_stall;
   logic        rsp_open;
   logic [16:0] rsp_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_open  = rsp_tvalid && !rsp_tlast;
   assign rsp_beat  = {rsp_tdata, rsp_tlast};

   // Hold a stalled result transaction.
   `UTF7D_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_tvalid && $stable(rsp_beat)), "rsp not held")

   // Come out of reset empty and ready.
   `UTF7D_ASSERT_RST(a_reset_empty, reset |=> (!rsp_tvalid && req_tready), "not empty after reset")

   // The first unit of a two-unit run is always a high surrogate.
   `UTF7D_ASSERT(a_pair_high, rsp_open |-> (rsp_tdata[15:10] == 6'b110110), "no high surrogate")

   // The partner unit is already buffered when the first one leaves.
   `UTF7D_ASSERT(a_pair_follow, (rsp_open && rsp_tready) |=> rsp_tvalid, "pair partner missing")

endmodule

bind utf7_to_utf16_decoder utf7d_checker u_utf7d_checker (.*);

FILE: tb/sv/utf7_to_utf16_decoder_checker.sv
`timescale 1ns / 1ps

module utf7_to_utf16_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] string_start
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] code_unit
   input  logic        rsp_tlast,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output int          mismatch_count,
   output int          units_outstanding
);

   import utf7d_pkg::*;

   // Decoder state, mirrored.
   logic       base64_at_start;
   logic [1:0] mode;
   logic [1:0] slot;
   logic [7:0] carry;
   logic [2:0] held;
   logic [7:0] unit_bytes [4];

   utf7d_beat_type expected_units [$];
   int failures = 0;

   // Base64 symbol value, or -1 for any other byte.
   function automatic int symbol_of(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == CHAR_PLUS) return 62;
      if (c == CHAR_SLASH) return 63;
      return -1;
   endfunction

   // Advance the mirrored state by one byte and queue the units it yields.
   function automatic void decode_byte(input logic [7:0] b, input logic first);
      int             v;
      logic [5:0]     sym;
      logic [7:0]     nb;
      logic           got;
      logic           in_shift;
      int             n;
      logic [15:0]    u [2];
      utf7d_beat_type beat;
      n = 0;
      nb = 8'h00;
      if (first) begin
         slot = 2'd0;
         carry = 8'h00;
         held = 3'd0;
         mode = base64_at_start ? MODE_B64 : MODE_DIRECT;
      end
      if (mode == MODE_PLUS && b == CHAR_MINUS) begin
         mode = MODE_DIRECT;
         u[n] = {8'h00, CHAR_PLUS};
         n++;
      end else begin
         if (mode == MODE_PLUS) begin
            mode = MODE_B64;
            slot = 2'd0;
            carry = 8'h00;
            held = 3'd0;
         end
         in_shift = (mode == MODE_B64);
         v = symbol_of(b);
         if (in_shift && v >= 0) begin
            sym = v[5:0];
            got = 1'b1;
            case (slot)
               2'd0: begin
                  carry = {sym, 2'b00};
                  got = 1'b0;
               end
               2'd1: begin
                  nb = carry | {6'b0, sym[5:4]};
                  carry = {sym[3:0], 4'b0000};
               end
               2'd2: begin
                  nb = carry | {4'b0, sym[5:2]};
                  carry = {sym[1:0], 6'b000000};
               end
               default: begin
                  nb = carry | {2'b0, sym};
               end
            endcase
            slot = slot + 2'd1;
            if (got) begin
               unit_bytes[held[1:0]] = nb;
               held = held + 3'd1;
               if (held == 3'd2 &&
                   (unit_bytes[0] < SURR_FIRST || unit_bytes[0] >= SURR_LIMIT)) begin
                  u[n] = {unit_bytes[0], unit_bytes[1]};
                  n++;
                  held = 3'd0;
               end else if (held >= 3'd4) begin
                  u[0] = {unit_bytes[0], unit_bytes[1]};
                  u[1] = {unit_bytes[2], unit_bytes[3]};
                  n = 2;
                  held = 3'd0;
               end
            end
         end else begin
            if (in_shift) begin
               mode = MODE_DIRECT;
               held = 3'd0;
            end
            // A '-' that closes a shift is consumed.
            if (!(in_shift && b == CHAR_MINUS)) begin
               if (b == CHAR_PLUS) begin
                  mode = MODE_PLUS;
               end else begin
                  mode = MODE_DIRECT;
                  u[n] = {8'h00, b};
                  n++;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         beat.code_unit = u[i];
         beat.last_of_run = (i == n - 1);
         expected_units.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin : watch
      utf7d_beat_type want;
      if (reset) begin
         base64_at_start = 1'b0;
         mode = MODE_DIRECT;
         slot = 2'd0;
         carry = 8'h00;
         held = 3'd0;
         expected_units.delete();
      end else begin
         if (csr_write_enable)
            base64_at_start = csr_write_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               $error("code_unit: expected none, actual %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_units.pop_front();
               if (rsp_tdata !== want.code_unit) begin
                  $error("code_unit: expected %h, actual %h", want.code_unit, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b", want.last_of_run, rsp_tlast);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tuser);
      end
      mismatch_count <= failures;
      units_outstanding <= expected_units.size();
   end

endmodule

FILE: tb/sv/utf7_to_utf16_decoder_test.sv
`timescale 1ns / 1ps

module utf7_to_utf16_decoder_test;

   import utf7d_pkg::*;

   // Worst case per byte: a long sender gap plus two units each behind a long
   // receiver stall; take that several times over.
   localparam int CYCLE_LIMIT     = 1_000_000;
   // Idle margin after the last predicted unit is taken, for bytes with no unit.
   localparam int SETTLE_CYCLES   = 8;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int PHASES          = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;       // [7:0] text_byte
   logic        req_tuser = 1'b0;        // [0] string_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // [15:0] code_unit
   logic        rsp_tlast;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   int mismatch_count;
   int units_outstanding;
   int cycle_count = 0;
   int items_sent = 0;

   // Stimulus knobs, changed between phases.
   bit start_cfg = 1'b0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   always #5 clock = ~clock;

   utf7_to_utf16_decoder uut (.*);

   utf7_to_utf16_decoder_checker unit_check (.*);

   // Abort a run that stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** utf7_to_utf16_decoder: FAILED **");
         $finish;
      end
   end

   // Throttle the result side: bursts of ready, then mostly short stalls with
   // an occasional long one. With stalls off, hold ready high.
   initial begin : rsp_backpressure
      int burst;
      int gap;
      int pick;
      forever begin
         rsp_tready <= 1'b1;
         burst = $urandom_range(1, 30);
         repeat (burst) @(posedge clock);
         gap = 0;
         if (rsp_stalls_on) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               gap = $urandom_range(1, 3);
            else if (pick < 70)
               gap = $urandom_range(8, 40);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   function automatic bit is_symbol(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9") || c == CHAR_PLUS || c == CHAR_SLASH;
   endfunction

   // Base64 alphabet character for a 6-bit value.
   function automatic logic [7:0] symbol_char(input logic [5:0] v);
      if (v < 6'd26) return 8'h41 + {2'b00, v};
      if (v < 6'd52) return 8'h47 + {2'b00, v};
      if (v < 6'd62) return {2'b00, v} - 8'd4;
      if (v == 6'd62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Offer one byte, optionally after an idle gap, and hold it until the
   // transaction completes.
   task automatic send_byte(input logic [7:0] b, input bit first);
      int gap;
      int pick;
      gap = 0;
      if (req_gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            gap = $urandom_range(1, 3);
         else if (pick < 30)
            gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_string(input string s, input bit first);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], first && i == 0);
   endtask

   // Drop valid and wait until every predicted unit has been taken, then let
   // the pipeline settle for bytes that produce no unit.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (units_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the start mode bit only while the block is idle.
   task automatic set_start_mode(input bit value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      start_cfg = value;
   endtask

   // One random sequence: mostly well-formed direct text or base64 shifts
   // with random content, the rest noise.
   task automatic send_random_sequence();
      bit          first;
      int          kind;
      int          count;
      int          pick;
      int          left;
      logic [7:0]  b;
      logic [15:0] u;
      logic [23:0] group;
      logic [7:0]  packed_bytes [$];
      first = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         // Direct text; a '+' goes out as the escaped pair.
         count = $urandom_range(1, 8);
         repeat (count) begin
            if ($urandom_range(0, 9) == 0)
               b = 8'($urandom_range(1, 255));
            else
               b = 8'($urandom_range(8'h20, 8'h7E));
            if (b == CHAR_PLUS) begin
               send_byte(CHAR_PLUS, first);
               send_byte(CHAR_MINUS, 1'b0);
            end else begin
               send_byte(b, first);
            end
            first = 1'b0;
         end
      end else if (kind < 85) begin
         // Shift: encode random units, a share of them surrogate pairs.
         count = $urandom_range(1, 6);
         repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               u = 16'hD800 | 16'($urandom_range(0, 1023));
               packed_bytes.push_back(u[15:8]);
               packed_bytes.push_back(u[7:0]);
               if (pick < 20)
                  u = 16'hDC00 | 16'($urandom_range(0, 1023));
               else
                  u = 16'($urandom);
            end else begin
               u = 16'($urandom);
            end
            packed_bytes.push_back(u[15:8]);
            packed_bytes.push_back(u[7:0]);
         end
         // Sometimes cut the last byte to leave a partial unit behind.
         if ($urandom_range(0, 9) == 0)
            void'(packed_bytes.pop_back());
         if (!(first && start_cfg)) begin
            send_byte(CHAR_PLUS, first);
            first = 1'b0;
         end
         for (int i = 0; i < packed_bytes.size(); i += 3) begin
            left = packed_bytes.size() - i;
            group = {packed_bytes[i],
                     left > 1 ? packed_bytes[i + 1] : 8'h00,
                     left > 2 ? packed_bytes[i + 2] : 8'h00};
            send_byte(symbol_char(group[23:18]), first);
            first = 1'b0;
            send_byte(symbol_char(group[17:12]), 1'b0);
            if (left > 1)
               send_byte(symbol_char(group[11:6]), 1'b0);
            if (left > 2)
               send_byte(symbol_char(group[5:0]), 1'b0);
         end
         // Close with '-', with a direct byte, or not at all.
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            send_byte(CHAR_MINUS, 1'b0);
         end else if (pick < 8) begin
            b = 8'($urandom_range(1, 255));
            while (is_symbol(b)) b = 8'($urandom_range(1, 255));
            send_byte(b, 1'b0);
         end
      end else begin
         // Noise: any nonzero byte, string starts anywhere.
         count = $urandom_range(1, 6);
         repeat (count) begin
            send_byte(8'($urandom_range(1, 255)), first || $urandom_range(0, 7) == 0);
            first = 1'b0;
         end
      end
   endtask

   initial begin : stimulus
      int phase_end;
      int pause_at;
      bit paused;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, start mode at its reset value: direct extremes, escaped
      // plus, a shift closed by a direct byte, a surrogate pair, an all-ones
      // unit and a zero byte ending a shift.
      send_byte(8'h41, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_string("+-", 1'b0);
      send_string("+AGE.", 1'b0);
      send_string("+2D3cAA-", 1'b0);
      send_string("+///", 1'b0);
      send_byte(8'h00, 1'b0);

      // Directed, strings open in base64: an unpaired high surrogate takes the
      // next two bytes whatever they hold; then close and go direct.
      set_start_mode(1'b1);
      send_string("2DAAAA-x", 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         req_gaps_on = (phase != 2);
         rsp_stalls_on = (phase != 2) && (phase != 3) || (phase == 3);
         if (phase == 2) rsp_stalls_on = 1'b0;
         set_start_mode(phase % 2 == 0);
         phase_end = items_sent + ITEMS_PER_PHASE;
         pause_at = items_sent + $urandom_range(100, 350);
         paused = 1'b0;
         while (items_sent < phase_end) begin
            send_random_sequence();
            // Hold off once per phase until the result side is empty.
            if (!paused && items_sent >= pause_at) begin
               drain_results();
               paused = 1'b1;
            end
         end
      end

      drain_results();
      if (mismatch_count == 0)
         $display("** utf7_to_utf16_decoder: PASSED **");
      else
         $display("** utf7_to_utf16_decoder: FAILED **");
      $finish;
   end

endmodule
